FILE: design/scaled_font_text_renderer_assert.svh
// assertion macros shared by the renderer modules
`ifndef SCALED_FONT_TEXT_RENDERER_ASSERT_SVH
`define SCALED_FONT_TEXT_RENDERER_ASSERT_SVH

// same-cycle implication, checked at every rising edge out of reset
`define SFTR_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sftr assertion failed");

// next-cycle implication
`define SFTR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sftr assertion failed");

`endif

FILE: design/sftr_pkg.sv
`timescale 1ns / 1ps

package sftr_pkg;

   localparam int SCREEN_WIDTH_DEFAULT  = 128;
   localparam int SCREEN_HEIGHT_DEFAULT = 128;

   // cursor column never exceeds max(1023, screen width)
   localparam int COL_W = 11;
   localparam int ROW_W = 16;

   localparam int JOB_DEPTH = 2;

   localparam logic [7:0] CHAR_END     = 8'd0;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_FIRST   = 8'd32;
   localparam logic [7:0] CHAR_LAST    = 8'd127;
   // glyph of '?'
   localparam logic [6:0] GLYPH_UNKNOWN = 7'd31;

   localparam logic [2:0] LAST_COL   = 3'd5;
   localparam logic [2:0] LAST_ROW   = 3'd7;
   localparam logic [2:0] GLYPH_COLS = 3'd5;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X    = 3'd0,
      CSR_ORIGIN_Y    = 3'd1,
      CSR_FORE_COLOR  = 3'd2,
      CSR_BACK_COLOR  = 3'd3,
      CSR_PIXEL_SCALE = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [9:0]  origin_x;
      logic [9:0]  origin_y;
      logic [15:0] fore_color;
      logic [15:0] back_color;
      logic [7:0]  pixel_scale;
   } cfg_type;

   typedef struct packed {
      logic [6:0] glyph;
      logic [9:0] x;
      logic [9:0] y;
   } job_type;

   typedef logic [0:4][7:0] glyph_type;

   localparam glyph_type GLYPH_ROM [96] = '{
      '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0},         '{8'd0, 8'd0, 8'd95, 8'd0, 8'd0},
      '{8'd0, 8'd7, 8'd0, 8'd7, 8'd0},         '{8'd20, 8'd127, 8'd20, 8'd127, 8'd20},
      '{8'd36, 8'd42, 8'd127, 8'd42, 8'd18},   '{8'd35, 8'd19, 8'd8, 8'd100, 8'd98},
      '{8'd54, 8'd73, 8'd85, 8'd34, 8'd80},    '{8'd0, 8'd5, 8'd3, 8'd0, 8'd0},
      '{8'd0, 8'd28, 8'd34, 8'd65, 8'd0},      '{8'd0, 8'd65, 8'd34, 8'd28, 8'd0},
      '{8'd20, 8'd8, 8'd62, 8'd8, 8'd20},      '{8'd8, 8'd8, 8'd62, 8'd8, 8'd8},
      '{8'd0, 8'd80, 8'd48, 8'd0, 8'd0},       '{8'd8, 8'd8, 8'd8, 8'd8, 8'd8},
      '{8'd0, 8'd96, 8'd96, 8'd0, 8'd0},       '{8'd32, 8'd16, 8'd8, 8'd4, 8'd2},
      '{8'd62, 8'd81, 8'd73, 8'd69, 8'd62},    '{8'd0, 8'd66, 8'd127, 8'd64, 8'd0},
      '{8'd66, 8'd97, 8'd81, 8'd73, 8'd70},    '{8'd33, 8'd65, 8'd69, 8'd75, 8'd49},
      '{8'd24, 8'd20, 8'd18, 8'd127, 8'd16},   '{8'd39, 8'd69, 8'd69, 8'd69, 8'd57},
      '{8'd60, 8'd74, 8'd73, 8'd73, 8'd48},    '{8'd1, 8'd113, 8'd9, 8'd5, 8'd3},
      '{8'd54, 8'd73, 8'd73, 8'd73, 8'd54},    '{8'd6, 8'd73, 8'd73, 8'd41, 8'd30},
      '{8'd0, 8'd54, 8'd54, 8'd0, 8'd0},       '{8'd0, 8'd86, 8'd54, 8'd0, 8'd0},
      '{8'd8, 8'd20, 8'd34, 8'd65, 8'd0},      '{8'd20, 8'd20, 8'd20, 8'd20, 8'd20},
      '{8'd0, 8'd65, 8'd34, 8'd20, 8'd8},      '{8'd2, 8'd1, 8'd81, 8'd9, 8'd6},
      '{8'd50, 8'd73, 8'd121, 8'd65, 8'd62},   '{8'd126, 8'd17, 8'd17, 8'd17, 8'd126},
      '{8'd127, 8'd73, 8'd73, 8'd73, 8'd54},   '{8'd62, 8'd65, 8'd65, 8'd65, 8'd34},
      '{8'd127, 8'd65, 8'd65, 8'd34, 8'd28},   '{8'd127, 8'd73, 8'd73, 8'd73, 8'd65},
      '{8'd127, 8'd9, 8'd9, 8'd9, 8'd1},       '{8'd62, 8'd65, 8'd73, 8'd73, 8'd122},
      '{8'd127, 8'd8, 8'd8, 8'd8, 8'd127},     '{8'd0, 8'd65, 8'd127, 8'd65, 8'd0},
      '{8'd32, 8'd64, 8'd65, 8'd63, 8'd1},     '{8'd127, 8'd8, 8'd20, 8'd34, 8'd65},
      '{8'd127, 8'd64, 8'd64, 8'd64, 8'd64},   '{8'd127, 8'd2, 8'd12, 8'd2, 8'd127},
      '{8'd127, 8'd4, 8'd8, 8'd16, 8'd127},    '{8'd62, 8'd65, 8'd65, 8'd65, 8'd62},
      '{8'd127, 8'd9, 8'd9, 8'd9, 8'd6},       '{8'd62, 8'd65, 8'd81, 8'd33, 8'd94},
      '{8'd127, 8'd9, 8'd25, 8'd41, 8'd70},    '{8'd70, 8'd73, 8'd73, 8'd73, 8'd49},
      '{8'd1, 8'd1, 8'd127, 8'd1, 8'd1},       '{8'd63, 8'd64, 8'd64, 8'd64, 8'd63},
      '{8'd31, 8'd32, 8'd64, 8'd32, 8'd31},    '{8'd63, 8'd64, 8'd56, 8'd64, 8'd63},
      '{8'd99, 8'd20, 8'd8, 8'd20, 8'd99},     '{8'd3, 8'd4, 8'd120, 8'd4, 8'd3},
      '{8'd97, 8'd81, 8'd73, 8'd69, 8'd67},    '{8'd0, 8'd127, 8'd65, 8'd65, 8'd0},
      '{8'd2, 8'd4, 8'd8, 8'd16, 8'd32},       '{8'd0, 8'd65, 8'd65, 8'd127, 8'd0},
      '{8'd4, 8'd2, 8'd1, 8'd2, 8'd4},         '{8'd64, 8'd64, 8'd64, 8'd64, 8'd64},
      '{8'd0, 8'd1, 8'd2, 8'd4, 8'd0},         '{8'd32, 8'd84, 8'd84, 8'd84, 8'd120},
      '{8'd127, 8'd72, 8'd68, 8'd68, 8'd56},   '{8'd56, 8'd68, 8'd68, 8'd68, 8'd32},
      '{8'd56, 8'd68, 8'd68, 8'd72, 8'd127},   '{8'd56, 8'd84, 8'd84, 8'd84, 8'd24},
      '{8'd8, 8'd126, 8'd9, 8'd1, 8'd2},       '{8'd12, 8'd82, 8'd82, 8'd82, 8'd62},
      '{8'd127, 8'd8, 8'd4, 8'd4, 8'd120},     '{8'd0, 8'd68, 8'd125, 8'd64, 8'd0},
      '{8'd32, 8'd64, 8'd68, 8'd61, 8'd0},     '{8'd127, 8'd16, 8'd40, 8'd68, 8'd0},
      '{8'd0, 8'd65, 8'd127, 8'd64, 8'd0},     '{8'd124, 8'd4, 8'd24, 8'd4, 8'd120},
      '{8'd124, 8'd8, 8'd4, 8'd4, 8'd120},     '{8'd56, 8'd68, 8'd68, 8'd68, 8'd56},
      '{8'd124, 8'd20, 8'd20, 8'd20, 8'd8},    '{8'd8, 8'd20, 8'd20, 8'd24, 8'd124},
      '{8'd124, 8'd8, 8'd4, 8'd4, 8'd8},       '{8'd72, 8'd84, 8'd84, 8'd84, 8'd32},
      '{8'd4, 8'd63, 8'd68, 8'd64, 8'd32},     '{8'd60, 8'd64, 8'd64, 8'd32, 8'd124},
      '{8'd28, 8'd32, 8'd64, 8'd32, 8'd28},    '{8'd60, 8'd64, 8'd48, 8'd64, 8'd60},
      '{8'd68, 8'd40, 8'd16, 8'd40, 8'd68},    '{8'd12, 8'd80, 8'd80, 8'd80, 8'd60},
      '{8'd68, 8'd100, 8'd84, 8'd76, 8'd68},   '{8'd0, 8'd8, 8'd54, 8'd65, 8'd0},
      '{8'd0, 8'd0, 8'd127, 8'd0, 8'd0},       '{8'd0, 8'd65, 8'd54, 8'd8, 8'd0},
      '{8'd8, 8'd4, 8'd8, 8'd16, 8'd8},        '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
   };

   // bytes outside the printable range draw as '?'
   function automatic logic [6:0] glyph_index(input logic [7:0] code);
      logic [7:0] offset;
      offset = code - CHAR_FIRST;
      if (code < CHAR_FIRST || code > CHAR_LAST) begin
         return GLYPH_UNKNOWN;
      end
      return offset[6:0];
   endfunction

endpackage

FILE: design/sftr_front.sv
`timescale 1ns / 1ps

module sftr_front #(
   parameter int SCREEN_WIDTH  = sftr_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = sftr_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [7:0]        req_char_code,
   input  logic              req_string_start,
   output logic              req_full,
   input  sftr_pkg::cfg_type cfg,
   output logic              job_push,
   output sftr_pkg::job_type job,
   input  logic              job_full
);

   localparam logic [sftr_pkg::COL_W:0] WIDTH_LIMIT  = (sftr_pkg::COL_W + 1)'(SCREEN_WIDTH);
   localparam logic [sftr_pkg::ROW_W:0] HEIGHT_LIMIT = (sftr_pkg::ROW_W + 1)'(SCREEN_HEIGHT);

   logic [sftr_pkg::COL_W-1:0] col_ff, col_in, col_eff;
   logic [sftr_pkg::ROW_W-1:0] row_ff, row_in, row_eff;
   logic                       stopped_ff, stopped_in, stopped_eff;
   logic                       accept;
   logic [10:0]                step_x, step_y;
   logic [sftr_pkg::COL_W:0]   col_sum;
   logic [sftr_pkg::ROW_W:0]   row_sum;
   logic                       fits;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;

   always_comb begin
      col_eff     = req_string_start ? {1'b0, cfg.origin_x} : col_ff;
      row_eff     = req_string_start ? {6'd0, cfg.origin_y} : row_ff;
      stopped_eff = req_string_start ? 1'b0 : stopped_ff;
      step_x      = ({3'd0, cfg.pixel_scale} << 2) + ({3'd0, cfg.pixel_scale} << 1);
      step_y      = {cfg.pixel_scale, 3'd0};
      col_sum     = {1'b0, col_eff} + {1'b0, step_x};
      row_sum     = {1'b0, row_eff} + {6'd0, step_y};
      fits        = (cfg.pixel_scale != 8'd0) && (col_sum <= WIDTH_LIMIT)
                    && (row_sum <= HEIGHT_LIMIT);
      job.glyph   = sftr_pkg::glyph_index(req_char_code);
      job.x       = col_eff[9:0];
      job.y       = row_eff[9:0];
   end

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      stopped_in = stopped_ff;
      job_push   = 1'b0;
      if (accept) begin
         col_in     = col_eff;
         row_in     = row_eff;
         stopped_in = stopped_eff;
         if (!stopped_eff) begin
            if (req_char_code == sftr_pkg::CHAR_END) begin
               stopped_in = 1'b1;
            end else if (req_char_code == sftr_pkg::CHAR_NEWLINE) begin
               col_in = {1'b0, cfg.origin_x};
               // row saturates instead of wrapping
               row_in = row_sum[sftr_pkg::ROW_W] ? '1 : row_sum[sftr_pkg::ROW_W-1:0];
            end else if (!fits) begin
               stopped_in = 1'b1;
            end else begin
               job_push = 1'b1;
               col_in   = col_sum[sftr_pkg::COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         stopped_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

FILE: design/sftr_queue.sv
`timescale 1ns / 1ps
`include "scaled_font_text_renderer_assert.svh"

module sftr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sftr_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output sftr_pkg::job_type pop_data
);

   localparam int PTR_W = $clog2(sftr_pkg::JOB_DEPTH);
   localparam int CNT_W = $clog2(sftr_pkg::JOB_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(sftr_pkg::JOB_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(sftr_pkg::JOB_DEPTH - 1);

   sftr_pkg::job_type slot_ff [sftr_pkg::JOB_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == DEPTH_CNT);
   assign valid    = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `SFTR_ASSERT_IMPL(queue_no_overfill, clock, reset, 1'b1, count_ff <= DEPTH_CNT)
   `SFTR_ASSERT_IMPL(queue_push_has_room, clock, reset, push, !full)
   `SFTR_ASSERT_NEXT(queue_pop_drains, clock, reset, do_pop && !do_push, count_ff == $past(count_ff) - 1'b1)

endmodule

FILE: design/sftr_back.sv
`timescale 1ns / 1ps
`include "scaled_font_text_renderer_assert.svh"

module sftr_back (
   input  logic              clock,
   input  logic              reset,
   input  sftr_pkg::cfg_type cfg,
   input  logic              job_valid,
   input  sftr_pkg::job_type job,
   output logic              job_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [9:0]        rsp_cell_x,
   output logic [9:0]        rsp_cell_y,
   output logic [15:0]       rsp_cell_color,
   output logic              rsp_last_cell
);

   logic                 busy_ff, busy_in;
   logic [2:0]           col_ff, col_in;
   logic [2:0]           row_ff, row_in;
   logic [9:0]           x_ff, x_in;
   logic [9:0]           y_ff, y_in;
   logic [9:0]           base_y_ff, base_y_in;
   sftr_pkg::glyph_type  glyph_ff, glyph_in;
   logic                 out_valid_ff, out_valid_in;
   logic [9:0]           out_x_ff, out_y_ff;
   logic [15:0]          out_color_ff;
   logic                 out_last_ff;
   logic                 advance, at_last, load, lit;
   logic [7:0]           col_bits;

   assign advance = busy_ff && (!out_valid_ff || rsp_pop);
   assign at_last = (col_ff == sftr_pkg::LAST_COL) && (row_ff == sftr_pkg::LAST_ROW);
   assign load    = job_valid && (!busy_ff || (advance && at_last));
   assign job_pop = load;

   always_comb begin
      // spacing column and spacing row are always background
      col_bits = (col_ff < sftr_pkg::GLYPH_COLS) ? glyph_ff[col_ff] : 8'd0;
      lit      = (row_ff != sftr_pkg::LAST_ROW) && col_bits[row_ff];
   end

   always_comb begin
      busy_in   = busy_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      base_y_in = base_y_ff;
      glyph_in  = glyph_ff;
      if (advance) begin
         if (row_ff == sftr_pkg::LAST_ROW) begin
            row_in = '0;
            col_in = col_ff + 1'b1;
            x_in   = x_ff + {2'd0, cfg.pixel_scale};
            y_in   = base_y_ff;
         end else begin
            row_in = row_ff + 1'b1;
            y_in   = y_ff + {2'd0, cfg.pixel_scale};
         end
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in   = 1'b1;
         col_in    = '0;
         row_in    = '0;
         x_in      = job.x;
         y_in      = job.y;
         base_y_in = job.y;
         glyph_in  = sftr_pkg::GLYPH_ROM[job.glyph];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      col_ff    <= col_in;
      row_ff    <= row_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      base_y_ff <= base_y_in;
      glyph_ff  <= glyph_in;
      if (advance) begin
         out_x_ff     <= x_ff;
         out_y_ff     <= y_ff;
         out_color_ff <= lit ? cfg.fore_color : cfg.back_color;
         out_last_ff  <= at_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_cell_x     = out_x_ff;
   assign rsp_cell_y     = out_y_ff;
   assign rsp_cell_color = out_color_ff;
   assign rsp_last_cell  = out_last_ff;

   `SFTR_ASSERT_NEXT(back_last_flag, clock, reset, advance && at_last, out_valid_ff && out_last_ff)
   `SFTR_ASSERT_IMPL(back_idle_after_last, clock, reset, $fell(busy_ff), out_last_ff)
   `SFTR_ASSERT_IMPL(back_load_when_free, clock, reset, load && busy_ff, advance && at_last)

endmodule

FILE: design/scaled_font_text_renderer.sv
`timescale 1ns / 1ps
// Text renderer: turns a byte stream into filled square cells of a scaled 5x7 font.
// Input queue: raise req_push with req_char_code and req_string_start; the byte is
// taken at an edge where req_full is low. req_string_start moves the cursor to the
// origin and restarts a stopped string.
// Result queue: while rsp_empty is low the oldest cell waits on rsp_cell_x, rsp_cell_y,
// rsp_cell_color and rsp_last_cell; it is taken at an edge with rsp_pop high.
// A printable byte gives 48 cells, column by column, top row first; the 48th has
// rsp_last_cell set. Newline, zero byte, bytes of a stopped string and characters
// that do not fit give no cells. A taken byte passes through the job queue and the
// registers of the back-end sequencer before its cells reach the registered result
// ports. Throughput: one cell per cycle while rsp_pop keeps the result port free, set
// by the cell sequencer in the back end; a two-entry job queue lets the front take
// the next bytes meanwhile.
// When rsp_pop stays low the sequencer holds, the job queue fills and req_full rises.
// csr_* writes the registers (always ready); write them only while the block is idle.
// Reset (synchronous) sets the cursor to (0,0), clears the stop flag, empties both
// queues and loads the register defaults.

module scaled_font_text_renderer #(
   parameter int SCREEN_WIDTH  = sftr_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = sftr_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_char_code,
   input  logic        req_string_start,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [9:0]  rsp_cell_x,
   output logic [9:0]  rsp_cell_y,
   output logic [15:0] rsp_cell_color,
   output logic        rsp_last_cell,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   sftr_pkg::cfg_type cfg_ff, cfg_in;
   sftr_pkg::job_type front_job, queue_job;
   logic              job_push, job_full, job_valid, job_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            sftr_pkg::CSR_ORIGIN_X:    cfg_in.origin_x    = csr_wdata[9:0];
            sftr_pkg::CSR_ORIGIN_Y:    cfg_in.origin_y    = csr_wdata[9:0];
            sftr_pkg::CSR_FORE_COLOR:  cfg_in.fore_color  = csr_wdata;
            sftr_pkg::CSR_BACK_COLOR:  cfg_in.back_color  = csr_wdata;
            sftr_pkg::CSR_PIXEL_SCALE: cfg_in.pixel_scale = csr_wdata[7:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x    <= 10'd0;
         cfg_ff.origin_y    <= 10'd0;
         cfg_ff.fore_color  <= 16'hFFFF;
         cfg_ff.back_color  <= 16'h0000;
         cfg_ff.pixel_scale <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sftr_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_char_code    (req_char_code),
      .req_string_start (req_string_start),
      .req_full         (req_full),
      .cfg              (cfg_ff),
      .job_push         (job_push),
      .job              (front_job),
      .job_full         (job_full)
   );

   sftr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (front_job),
      .full      (job_full),
      .pop       (job_pop),
      .valid     (job_valid),
      .pop_data  (queue_job)
   );

   sftr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .job_valid      (job_valid),
      .job            (queue_job),
      .job_pop        (job_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_cell_x     (rsp_cell_x),
      .rsp_cell_y     (rsp_cell_y),
      .rsp_cell_color (rsp_cell_color),
      .rsp_last_cell  (rsp_last_cell)
   );

endmodule

FILE: dv/scaled_font_text_renderer_tb.sv
`timescale 1ns / 1ps

module scaled_font_text_renderer_tb;

   localparam int SCREEN_W        = sftr_pkg::SCREEN_WIDTH_DEFAULT;
   localparam int SCREEN_H        = sftr_pkg::SCREEN_HEIGHT_DEFAULT;
   localparam int FIRST_PRINTABLE = 32;
   localparam int LAST_PRINTABLE  = 127;
   localparam int CELLS_PER_CHAR  = 48;
   localparam logic [7:0] UNKNOWN_CHAR = "?";
   localparam int DRAIN_CYCLES    = 16;
   localparam int PHASE_ITEMS     = 5;

   // 5x7 font, five column bytes per glyph, bit 0 is the top row
   localparam bit [7:0] FONT_COLS [480] = '{
      0, 0, 0, 0, 0,         0, 0, 95, 0, 0,        0, 7, 0, 7, 0,
      20, 127, 20, 127, 20,  36, 42, 127, 42, 18,   35, 19, 8, 100, 98,
      54, 73, 85, 34, 80,    0, 5, 3, 0, 0,         0, 28, 34, 65, 0,
      0, 65, 34, 28, 0,      20, 8, 62, 8, 20,      8, 8, 62, 8, 8,
      0, 80, 48, 0, 0,       8, 8, 8, 8, 8,         0, 96, 96, 0, 0,
      32, 16, 8, 4, 2,       62, 81, 73, 69, 62,    0, 66, 127, 64, 0,
      66, 97, 81, 73, 70,    33, 65, 69, 75, 49,    24, 20, 18, 127, 16,
      39, 69, 69, 69, 57,    60, 74, 73, 73, 48,    1, 113, 9, 5, 3,
      54, 73, 73, 73, 54,    6, 73, 73, 41, 30,     0, 54, 54, 0, 0,
      0, 86, 54, 0, 0,       8, 20, 34, 65, 0,      20, 20, 20, 20, 20,
      0, 65, 34, 20, 8,      2, 1, 81, 9, 6,        50, 73, 121, 65, 62,
      126, 17, 17, 17, 126,  127, 73, 73, 73, 54,   62, 65, 65, 65, 34,
      127, 65, 65, 34, 28,   127, 73, 73, 73, 65,   127, 9, 9, 9, 1,
      62, 65, 73, 73, 122,   127, 8, 8, 8, 127,     0, 65, 127, 65, 0,
      32, 64, 65, 63, 1,     127, 8, 20, 34, 65,    127, 64, 64, 64, 64,
      127, 2, 12, 2, 127,    127, 4, 8, 16, 127,    62, 65, 65, 65, 62,
      127, 9, 9, 9, 6,       62, 65, 81, 33, 94,    127, 9, 25, 41, 70,
      70, 73, 73, 73, 49,    1, 1, 127, 1, 1,       63, 64, 64, 64, 63,
      31, 32, 64, 32, 31,    63, 64, 56, 64, 63,    99, 20, 8, 20, 99,
      3, 4, 120, 4, 3,       97, 81, 73, 69, 67,    0, 127, 65, 65, 0,
      2, 4, 8, 16, 32,       0, 65, 65, 127, 0,     4, 2, 1, 2, 4,
      64, 64, 64, 64, 64,    0, 1, 2, 4, 0,         32, 84, 84, 84, 120,
      127, 72, 68, 68, 56,   56, 68, 68, 68, 32,    56, 68, 68, 72, 127,
      56, 84, 84, 84, 24,    8, 126, 9, 1, 2,       12, 82, 82, 82, 62,
      127, 8, 4, 4, 120,     0, 68, 125, 64, 0,     32, 64, 68, 61, 0,
      127, 16, 40, 68, 0,    0, 65, 127, 64, 0,     124, 4, 24, 4, 120,
      124, 8, 4, 4, 120,     56, 68, 68, 68, 56,    124, 20, 20, 20, 8,
      8, 20, 20, 24, 124,    124, 8, 4, 4, 8,       72, 84, 84, 84, 32,
      4, 63, 68, 64, 32,     60, 64, 64, 32, 124,   28, 32, 64, 32, 28,
      60, 64, 48, 64, 60,    68, 40, 16, 40, 68,    12, 80, 80, 80, 60,
      68, 100, 84, 76, 68,   0, 8, 54, 65, 0,       0, 0, 127, 0, 0,
      0, 65, 54, 8, 0,       8, 4, 8, 16, 8,        0, 0, 0, 0, 0
   };

   typedef struct packed {
      logic [9:0]  x;
      logic [9:0]  y;
      logic [15:0] color;
      logic        last;
   } cell_rec_type;

   class text_cell_model;
      logic [9:0]  origin_x;
      logic [9:0]  origin_y;
      logic [15:0] fore;
      logic [15:0] back;
      logic [7:0]  scale;
      int unsigned col;
      int unsigned row;
      bit          stopped;
      cell_rec_type pending_cells[$];
      int unsigned handled;
      int unsigned drawn;
      int unsigned checked;
      int unsigned mismatches;

      function new();
         origin_x   = '0;
         origin_y   = '0;
         fore       = 16'hFFFF;
         back       = '0;
         scale      = 8'd1;
         col        = 0;
         row        = 0;
         stopped    = 1'b0;
         handled    = 0;
         drawn      = 0;
         checked    = 0;
         mismatches = 0;
      endfunction

      function void set_reg(sftr_pkg::csr_index_type idx, logic [15:0] value);
         case (idx)
            sftr_pkg::CSR_ORIGIN_X:    origin_x = value[9:0];
            sftr_pkg::CSR_ORIGIN_Y:    origin_y = value[9:0];
            sftr_pkg::CSR_FORE_COLOR:  fore = value;
            sftr_pkg::CSR_BACK_COLOR:  back = value;
            sftr_pkg::CSR_PIXEL_SCALE: scale = value[7:0];
            default: ;
         endcase
      endfunction

      function void take_byte(logic [7:0] code, bit start);
         int unsigned glyph;
         int unsigned step_x;
         int unsigned step_y;
         int unsigned bits;
         int unsigned cx;
         int unsigned ry;
         int unsigned pos;
         cell_rec_type rec;
         if (start) begin
            col     = origin_x;
            row     = origin_y;
            stopped = 1'b0;
         end
         if (stopped) begin
            return;
         end
         handled++;
         if (code == sftr_pkg::CHAR_END) begin
            stopped = 1'b1;
            return;
         end
         step_x = 6 * scale;
         step_y = 8 * scale;
         if (code == sftr_pkg::CHAR_NEWLINE) begin
            col = origin_x;
            row = (row + step_y > 16'hFFFF) ? 16'hFFFF : row + step_y;
            return;
         end
         if (scale == 0 || col + step_x > SCREEN_W || row + step_y > SCREEN_H) begin
            stopped = 1'b1;
            return;
         end
         if (code < FIRST_PRINTABLE || code > LAST_PRINTABLE) begin
            glyph = UNKNOWN_CHAR - FIRST_PRINTABLE;
         end else begin
            glyph = code - FIRST_PRINTABLE;
         end
         for (int k = 0; k < CELLS_PER_CHAR; k++) begin
            cx   = k / 8;
            ry   = k % 8;
            bits = (cx < 5) ? FONT_COLS[glyph * 5 + cx] : 0;
            pos  = col + cx * scale;
            rec.x = pos[9:0];
            pos  = row + ry * scale;
            rec.y = pos[9:0];
            rec.color = (ry < 7 && bits[ry]) ? fore : back;
            rec.last  = (k == CELLS_PER_CHAR - 1);
            pending_cells.push_back(rec);
         end
         col = (col + step_x) & 16'hFFFF;
         drawn++;
      endfunction

      task report(string what);
         $display("MISMATCH @%0t: %s", $time, what);
         mismatches++;
      endtask

      task check_cell(logic [9:0] x, logic [9:0] y, logic [15:0] color, logic last);
         cell_rec_type want;
         if (pending_cells.size() == 0) begin
            report($sformatf("cell at (%0d,%0d) with none expected", x, y));
            return;
         end
         want = pending_cells.pop_front();
         checked++;
         if (x !== want.x)
            report($sformatf("cell %0d: x %0d, expected %0d", checked, x, want.x));
         if (y !== want.y)
            report($sformatf("cell %0d: y %0d, expected %0d", checked, y, want.y));
         if (color !== want.color)
            report($sformatf("cell %0d: color %h, expected %h", checked, color, want.color));
         if (last !== want.last)
            report($sformatf("cell %0d: last %b, expected %b", checked, last, want.last));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_char_code = '0;
   logic        req_string_start = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [9:0]  rsp_cell_x;
   logic [9:0]  rsp_cell_y;
   logic [15:0] rsp_cell_color;
   logic        rsp_last_cell;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   sftr_pkg::csr_index_type csr_index = sftr_pkg::CSR_ORIGIN_X;
   logic [15:0] csr_wdata = '0;

   text_cell_model model;
   int push_idle_pct = 30;
   int pop_idle_pct  = 51;
   int settings_loaded = 0;

   scaled_font_text_renderer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_char_code    (req_char_code),
      .req_string_start (req_string_start),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_cell_x       (rsp_cell_x),
      .rsp_cell_y       (rsp_cell_y),
      .rsp_cell_color   (rsp_cell_color),
      .rsp_last_cell    (rsp_last_cell),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // both handshakes are sampled here, before any update of this edge lands
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         model.check_cell(rsp_cell_x, rsp_cell_y, rsp_cell_color, rsp_last_cell);
      end
      if (!reset && req_push && !req_full) begin
         model.take_byte(req_char_code, req_string_start);
      end
      rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
   end

   // push stays high from one item to the next unless a gap is drawn
   task automatic send_byte(input logic [7:0] code, input bit start);
      int gap;
      gap = 0;
      while ($urandom_range(99) < push_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_char_code    <= code;
      req_string_start <= start;
      do @(posedge clock); while (req_full);
   endtask

   // one idle edge first so the last accepted item is already in the model
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (model.pending_cells.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input sftr_pkg::csr_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      model.set_reg(idx, value);
   endtask

   task automatic load_settings(input logic [9:0] ox, input logic [9:0] oy,
                                input logic [15:0] fg, input logic [15:0] bg,
                                input logic [7:0] sc);
      drain();
      write_reg(sftr_pkg::CSR_ORIGIN_X, 16'(ox));
      write_reg(sftr_pkg::CSR_ORIGIN_Y, 16'(oy));
      write_reg(sftr_pkg::CSR_FORE_COLOR, fg);
      write_reg(sftr_pkg::CSR_BACK_COLOR, bg);
      write_reg(sftr_pkg::CSR_PIXEL_SCALE, 16'(sc));
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   task automatic random_settings();
      logic [9:0]  ox;
      logic [9:0]  oy;
      logic [15:0] fg;
      logic [15:0] bg;
      logic [7:0]  sc;
      int          pick;
      ox = ($urandom_range(99) < 75) ? 10'($urandom_range(40)) : 10'($urandom_range(1023));
      oy = ($urandom_range(99) < 75) ? 10'($urandom_range(40)) : 10'($urandom_range(1023));
      fg = 16'($urandom);
      bg = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 60)      sc = 8'd1;
      else if (pick < 85) sc = 8'($urandom_range(3, 2));
      else if (pick < 95) sc = 8'($urandom_range(8, 4));
      else                sc = 8'($urandom_range(21, 9));
      load_settings(ox, oy, fg, bg, sc);
   endtask

   // mostly printable text, with newlines, early ends and junk bytes mixed in
   task automatic send_string();
      int         len;
      int         pick;
      logic [7:0] code;
      bit         start;
      len = $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 70)      code = 8'($urandom_range(LAST_PRINTABLE, FIRST_PRINTABLE));
         else if (pick < 80) code = sftr_pkg::CHAR_NEWLINE;
         else if (pick < 84) code = sftr_pkg::CHAR_END;
         else if (pick < 89) code = 8'($urandom_range(FIRST_PRINTABLE - 1, 1));
         else if (pick < 94) code = 8'($urandom_range(255, LAST_PRINTABLE + 1));
         else                code = 8'($urandom_range(255));
         start = (i == 0) || ($urandom_range(99) < 3);
         send_byte(code, start);
      end
   endtask

   task automatic random_phase();
      int unsigned goal;
      random_settings();
      goal = model.handled + PHASE_ITEMS;
      while (model.handled < goal) begin
         send_string();
      end
   endtask

   initial begin
      model = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings, cursor at the corner before any string start
      send_byte("A", 1'b0);
      send_byte(" ", 1'b0);
      send_byte(8'(LAST_PRINTABLE), 1'b0);
      send_byte("~", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(sftr_pkg::CHAR_NEWLINE, 1'b0);
      send_byte("}", 1'b0);
      send_byte(sftr_pkg::CHAR_END, 1'b0);
      send_byte("B", 1'b0);
      send_byte("C", 1'b1);

      // last character that fits in the corner, then one past the edge
      load_settings(10'd122, 10'd120, 16'h0000, 16'hFFFF, 8'd1);
      send_byte("W", 1'b1);
      send_byte("X", 1'b0);
      send_byte("Y", 1'b0);

      load_settings(10'd0, 10'd0, 16'hA5A5, 16'h5A5A, 8'd16);
      send_byte("@", 1'b1);
      send_byte("%", 1'b0);

      load_settings(10'd1023, 10'd1023, 16'hFFFF, 16'h0000, 8'd255);
      send_byte("A", 1'b1);
      send_byte(sftr_pkg::CHAR_NEWLINE, 1'b1);

      // zero scale
      load_settings(10'd0, 10'd0, 16'h1234, 16'h8001, 8'd0);
      send_byte("A", 1'b1);
      send_byte(sftr_pkg::CHAR_NEWLINE, 1'b1);
      send_byte(UNKNOWN_CHAR, 1'b0);

      // push the row to its ceiling, then check it does not wrap at scale 1
      load_settings(10'd0, 10'd1023, 16'hFFFF, 16'h0000, 8'd255);
      send_byte(sftr_pkg::CHAR_NEWLINE, 1'b1);
      repeat (32) send_byte(sftr_pkg::CHAR_NEWLINE, 1'b0);
      load_settings(10'd0, 10'd1023, 16'hFFFF, 16'h0000, 8'd1);
      send_byte(sftr_pkg::CHAR_NEWLINE, 1'b0);
      send_byte("A", 1'b0);

      random_phase();
      random_phase();
      push_idle_pct = 51;
      pop_idle_pct  = 30;
      random_phase();
      random_phase();
      push_idle_pct = 0;
      pop_idle_pct  = 0;
      random_phase();
      random_phase();
      drain();

      $display("checked %0d cells from %0d drawn characters, %0d bytes acted on",
               model.checked, model.drawn, model.handled);
      $display("%0d register settings, scale 0 to 255, origins 0 to 1023, sender/receiver stalls",
               settings_loaded);
      if (model.mismatches == 0) begin
         $display("PASS scaled_font_text_renderer");
      end else begin
         $display("FAIL scaled_font_text_renderer");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d cells still expected", model.pending_cells.size());
      $display("FAIL scaled_font_text_renderer");
      $finish;
   end

endmodule
